### design/fqd_pkg.sv
// ----------------------------------------------------------------------------
// fqd_pkg
// Shared types and codes of the first-in first-out queue with delete by value.
// ----------------------------------------------------------------------------
package fqd_pkg;

   // request codes
   localparam logic [1:0] OP_ENQUEUE = 2'd0;
   localparam logic [1:0] OP_DEQUEUE = 2'd1;
   localparam logic [1:0] OP_DELETE  = 2'd2;

   // result status codes
   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_INVALID   = 2'd1;
   localparam logic [1:0] STATUS_NOT_FOUND = 2'd2;
   localparam logic [1:0] STATUS_FULL      = 2'd3;

   localparam int HANDLE_BITS = 32;
   localparam int LENGTH_BITS = 6;

   typedef struct packed {
      logic [1:0]             req_type;
      logic [HANDLE_BITS-1:0] handle_in;
   } fqd_req_type;

   typedef struct packed {
      logic [1:0]             status;
      logic [HANDLE_BITS-1:0] handle_out;
      logic [LENGTH_BITS-1:0] length;
   } fqd_rsp_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_SHIFT,
      ST_RESULT
   } fqd_state_type;

endpackage

### design/fifo_queue_with_delete.sv
// ----------------------------------------------------------------------------
// fifo_queue_with_delete
// Bounded first-in first-out queue of nonzero handles with delete by value.
// ----------------------------------------------------------------------------
// One item is taken at a time. An enqueue, and any rejected or unused request,
// goes straight on to post its result. A dequeue or a delete walks the entries
// through the single read port of the entry memory: it reads from the head
// until it finds the entry to remove, moves each following entry one slot
// towards the head to close the gap, and then posts the result; a dequeue
// takes the head, and a delete that finds nothing reads every held entry.
// The result sits in an output register, so the next item is taken while it
// waits to be collected.
module fifo_queue_with_delete #(
   parameter int DEPTH        = 32,
   parameter int HANDLE_WIDTH = 32
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  fqd_pkg::fqd_req_type req,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output fqd_pkg::fqd_rsp_type rsp
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int SW = (HANDLE_WIDTH < fqd_pkg::HANDLE_BITS) ? HANDLE_WIDTH
                                                              : fqd_pkg::HANDLE_BITS;

   logic                 res_valid;
   logic                 res_take;
   fqd_pkg::fqd_rsp_type res;
   logic                 wr_en;
   logic [AW-1:0]        wr_addr;
   logic [SW-1:0]        wr_data;
   logic [AW-1:0]        rd_addr;
   logic [SW-1:0]        rd_data;

   logic                 rsp_valid_ff, rsp_valid_in;
   fqd_pkg::fqd_rsp_type rsp_ff, rsp_in;

   fqd_ram #(
      .WIDTH (SW),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   fqd_seq #(
      .DEPTH (DEPTH),
      .SW    (SW)
   ) u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req       (req),
      .res_valid (res_valid),
      .res_take  (res_take),
      .res       (res),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_addr   (rd_addr),
      .rd_data   (rd_data)
   );

   // output register
   assign res_take = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (res_valid && res_take) begin
         rsp_valid_in = 1'b1;
         rsp_in       = res;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

endmodule

### design/fqd_ram.sv
// ----------------------------------------------------------------------------
// fqd_ram
// Generic single-write, single-read memory with registered read data.
// ----------------------------------------------------------------------------
module fqd_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32
) (
   input  logic                                       clock,
   input  logic                                       wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                           wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                           rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### design/fqd_seq.sv
// ----------------------------------------------------------------------------
// fqd_seq
// Sequencer of the queue: walks the entry memory through one read port and
// one compare unit, finds the entry to remove and closes the gap one slot a
// cycle.
// ----------------------------------------------------------------------------
module fqd_seq #(
   parameter int DEPTH = 32,
   parameter int SW    = 32
) (
   input  logic                                       clock,
   input  logic                                       reset,
   input  logic                                       req_valid,
   output logic                                       req_stall,
   input  fqd_pkg::fqd_req_type                       req,
   output logic                                       res_valid,
   input  logic                                       res_take,
   output fqd_pkg::fqd_rsp_type                       res,
   output logic                                       wr_en,
   output logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   output logic [SW-1:0]                              wr_data,
   output logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   input  logic [SW-1:0]                              rd_data
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   fqd_pkg::fqd_state_type state_ff, state_in;
   logic [1:0]    op_ff, op_in;
   logic [SW-1:0] h_ff, h_in;
   logic [CW-1:0] idx_ff, idx_in;
   logic [CW-1:0] count_ff, count_in;
   logic [1:0]    status_ff, status_in;
   logic [SW-1:0] hout_ff, hout_in;

   logic [SW-1:0] h_req;
   logic [CW:0]   idx_p1;
   logic [CW:0]   idx_p2;
   logic [CW:0]   count_x;
   logic          match;

   assign h_req   = req.handle_in[SW-1:0];
   assign idx_p1  = {1'b0, idx_ff} + (CW+1)'(1);
   assign idx_p2  = {1'b0, idx_ff} + (CW+1)'(2);
   assign count_x = {1'b0, count_ff};
   // the shared compare unit; a dequeue always takes the head
   assign match   = (op_ff == fqd_pkg::OP_DEQUEUE) || (rd_data == h_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= fqd_pkg::ST_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
      op_ff     <= op_in;
      h_ff      <= h_in;
      idx_ff    <= idx_in;
      status_ff <= status_in;
      hout_ff   <= hout_in;
   end

   always_comb begin
      state_in  = state_ff;
      op_in     = op_ff;
      h_in      = h_ff;
      idx_in    = idx_ff;
      count_in  = count_ff;
      status_in = status_ff;
      hout_in   = hout_ff;
      req_stall = 1'b1;
      res_valid = 1'b0;
      wr_en     = 1'b0;
      wr_addr   = idx_ff[AW-1:0];
      wr_data   = rd_data;
      rd_addr   = '0;
      case (state_ff)
         fqd_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               op_in     = req.req_type;
               h_in      = h_req;
               idx_in    = '0;
               hout_in   = '0;
               status_in = fqd_pkg::STATUS_OK;
               state_in  = fqd_pkg::ST_RESULT;
               case (req.req_type)
                  fqd_pkg::OP_ENQUEUE: begin
                     if (h_req == '0) begin
                        status_in = fqd_pkg::STATUS_INVALID;
                     end else if (count_ff == CW'(DEPTH)) begin
                        status_in = fqd_pkg::STATUS_FULL;
                     end else begin
                        wr_en    = 1'b1;
                        wr_addr  = count_ff[AW-1:0];
                        wr_data  = h_req;
                        count_in = count_ff + CW'(1);
                     end
                  end
                  fqd_pkg::OP_DEQUEUE: begin
                     if (count_ff == '0) begin
                        status_in = fqd_pkg::STATUS_INVALID;
                     end else begin
                        state_in = fqd_pkg::ST_SCAN;
                     end
                  end
                  fqd_pkg::OP_DELETE: begin
                     if (h_req == '0) begin
                        status_in = fqd_pkg::STATUS_INVALID;
                     end else if (count_ff == '0) begin
                        status_in = fqd_pkg::STATUS_NOT_FOUND;
                     end else begin
                        state_in = fqd_pkg::ST_SCAN;
                     end
                  end
                  default: begin
                     status_in = fqd_pkg::STATUS_OK;
                  end
               endcase
            end
         end
         fqd_pkg::ST_SCAN: begin
            if (match) begin
               if (op_ff == fqd_pkg::OP_DEQUEUE) begin
                  hout_in = rd_data;
               end
               if (idx_p1 == count_x) begin
                  count_in = count_ff - CW'(1);
                  state_in = fqd_pkg::ST_RESULT;
               end else begin
                  rd_addr  = idx_p1[AW-1:0];
                  state_in = fqd_pkg::ST_SHIFT;
               end
            end else if (idx_p1 == count_x) begin
               status_in = fqd_pkg::STATUS_NOT_FOUND;
               state_in  = fqd_pkg::ST_RESULT;
            end else begin
               idx_in  = idx_p1[CW-1:0];
               rd_addr = idx_p1[AW-1:0];
            end
         end
         fqd_pkg::ST_SHIFT: begin
            // move the following entry one slot towards the head
            wr_en   = 1'b1;
            wr_addr = idx_ff[AW-1:0];
            wr_data = rd_data;
            if (idx_p2 == count_x) begin
               count_in = count_ff - CW'(1);
               state_in = fqd_pkg::ST_RESULT;
            end else begin
               idx_in  = idx_p1[CW-1:0];
               rd_addr = idx_p2[AW-1:0];
            end
         end
         fqd_pkg::ST_RESULT: begin
            res_valid = 1'b1;
            if (res_take) begin
               state_in = fqd_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = fqd_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      res.status     = status_ff;
      res.handle_out = fqd_pkg::HANDLE_BITS'(hout_ff);
      res.length     = fqd_pkg::LENGTH_BITS'(count_ff);
   end

endmodule

### design/fqd_checker.sv
// ----------------------------------------------------------------------------
// fqd_checker
// Port-level checks of the queue, attached to the top level by bind.
// ----------------------------------------------------------------------------
module fqd_checker #(
   parameter int DEPTH = 32
) (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_valid,
   input logic                 req_stall,
   input logic                 rsp_valid,
   input logic                 rsp_stall,
   input fqd_pkg::fqd_rsp_type rsp
);

   // no item left over from before reset
   a_reset_clears : assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   // a held result keeps still
   a_rsp_hold : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp)))
      else $error("stalled result changed");

   // an accepted item leaves the block busy in the following cycle
   a_busy_after_accept : assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("item taken in back-to-back cycles");

   // a refused request hands back no handle
   a_reject_no_handle : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp.status != fqd_pkg::STATUS_OK)) |-> (rsp.handle_out == '0))
      else $error("handle returned with a failing status");

   // full is only reported with every slot taken
   a_full_length : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp.status == fqd_pkg::STATUS_FULL))
         |-> (rsp.length == fqd_pkg::LENGTH_BITS'(DEPTH)))
      else $error("full reported below capacity");

endmodule

bind fifo_queue_with_delete fqd_checker #(.DEPTH(DEPTH)) u_fqd_checker (.*);
